FILE: sv/llh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llh_pkg: shared types and constants for the latency histogram
// Item formats, function codes, bucket split points and the lower bound map.
// ----------------------------------------------------------------------------
package llh_pkg;

	// Function codes carried by a sample item
	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	// Bucket map split points
	localparam int SPLIT_LOW   = 11;
	localparam int SPLIT_HIGH  = 21;
	localparam int TAIL_OFFSET = 10;

	// Internal bucket number width (covers every legal bucket count)
	localparam int BKT7_W = 7;

	typedef struct packed {
		logic        func;
		logic [63:0] latency_us;
		logic [1:0]  op_class;
		logic        encrypted_op;
		logic [5:0]  read_bucket;
	} sample_t;

	typedef struct packed {
		logic [5:0]  bucket_index;
		logic [63:0] bucket_count;
		logic [40:0] bucket_lower_bound;
		logic [63:0] class_latency_sum;
		logic [63:0] class_op_count;
		logic [63:0] class_encrypted_sum;
	} result_t;

	// Per-class totals as stored in the totals memory
	typedef struct packed {
		logic [63:0] enc_sum;
		logic [63:0] op_cnt;
		logic [63:0] lat_sum;
	} totals_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP,
		ST_UPD
	} state_t;

	// Lowest latency that maps into bucket b
	function automatic logic [63:0] lower_bound_fn(input logic [BKT7_W-1:0] b);
		logic [BKT7_W-1:0] k;
		logic [5:0]        oct;
		logic [63:0]       v;
		k   = '0;
		oct = '0;
		v   = '0;
		if (b == '0) begin
			v = '0;
		end else if (b < BKT7_W'(SPLIT_LOW)) begin
			v = 64'd1 << b;
		end else if (b < BKT7_W'(SPLIT_LOW + 2 * (SPLIT_HIGH - SPLIT_LOW))) begin
			// half-octave buckets: even k is the octave start, odd k its midpoint
			k   = b - BKT7_W'(SPLIT_LOW);
			oct = 6'(SPLIT_LOW) + 6'(k >> 1);
			v   = (64'd1 << oct) | (k[0] ? (64'd1 << (oct - 6'd1)) : 64'd0);
		end else begin
			k = b - BKT7_W'(TAIL_OFFSET);
			if (k > BKT7_W'(63)) begin
				k = BKT7_W'(63);
			end
			v = 64'd1 << k[5:0];
		end
		return v;
	endfunction

endpackage

FILE: sv/llh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llh_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module llh_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 204,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/llh_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llh_map: bucket selection
// Maps a latency to its log-linear bucket (or saturates a requested bucket)
// and gives the bucket's lower bound.
// ----------------------------------------------------------------------------
module llh_map
	import llh_pkg::*;
#(
	parameter int NUM_BUCKETS = 51,
	parameter int BKT_W       = $clog2(NUM_BUCKETS)
) (
	input  logic              func,
	input  logic [63:0]       latency_us,
	input  logic [5:0]        read_bucket,
	output logic [BKT_W-1:0]  bucket,
	output logic [40:0]       lower_bound
);

	localparam logic [BKT7_W-1:0] LAST_BKT = BKT7_W'(NUM_BUCKETS - 1);

	logic [5:0]        top;
	logic [BKT7_W-1:0] map_b;
	logic [BKT7_W-1:0] sel_b;
	logic [63:0]       lb_full;

	// position of the highest set bit (zero for a zero latency)
	always_comb begin
		top = '0;
		for (int i = 0; i < 64; i++) begin
			if (latency_us[i]) begin
				top = 6'(i);
			end
		end
	end

	// log below the split, half octaves inside it, log plus offset above
	always_comb begin
		if (top < 6'(SPLIT_LOW)) begin
			map_b = {1'b0, top};
		end else if (top < 6'(SPLIT_HIGH)) begin
			map_b = ({1'b0, top} << 1) - BKT7_W'(SPLIT_LOW)
				+ BKT7_W'(latency_us[top - 6'd1]);
		end else begin
			map_b = {1'b0, top} + BKT7_W'(TAIL_OFFSET);
		end
	end

	// choose mapped or requested bucket, then clamp to the last bucket
	always_comb begin
		sel_b = (func == FUNC_RECORD) ? map_b : {1'b0, read_bucket};
		if (sel_b > LAST_BKT) begin
			sel_b = LAST_BKT;
		end
	end

	assign lb_full     = lower_bound_fn(sel_b);
	assign bucket      = BKT_W'(sel_b);
	assign lower_bound = lb_full[40:0];

endmodule

FILE: sv/log_linear_latency_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_linear_latency_histogram: per-class log-linear latency histogram
// Bucket counters and class totals kept in two RAMs, updated read-modify-write.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel (sample_valid / sample_stall / sample): a record item bumps
//   the bucket counter and the totals of its class; a read item returns one
//   bucket counter and the class totals without changing anything.
//   Result channel (result_valid / result_stall / result): one item per
//   sample item, in order, carrying the values after the update.
//   Each sample goes through an address step (RAM read) and a write-back
//   step before its result is registered; a new sample is taken only after
//   the read-modify-write of the bucket counter RAM is written back.
//   A finished result waits in the output register while the next sample is
//   accepted; if the receiver stalls, the write-back of that next sample
//   holds until the output register frees up, and sample_stall stays high.
//   Reset: after arst_n is released a clearing pass zeroes both RAMs, one
//   entry per cycle, over all NUM_CLASSES * NUM_BUCKETS entries (204 by default);
//   sample_stall is high throughout.
// ----------------------------------------------------------------------------
module log_linear_latency_histogram
	import llh_pkg::*;
#(
	parameter int NUM_CLASSES = 4,
	parameter int NUM_BUCKETS = 51
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	input  sample_t sample,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int DEPTH = NUM_CLASSES * NUM_BUCKETS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int BKT_W = $clog2(NUM_BUCKETS);
	localparam int TOT_W = $bits(totals_t);

	state_t state_q, state_d;

	logic [AW-1:0]    clr_q;
	sample_t          item_q;
	logic [BKT_W-1:0] bucket_q;
	logic [40:0]      lbound_q;
	logic [AW-1:0]    addr_q;
	logic             cls_ok_q;
	logic             rec_ok_q;
	result_t          out_q;
	logic             out_valid_q;

	logic [BKT_W-1:0] map_bucket;
	logic [40:0]      map_lbound;
	logic             cls_ok;
	logic [AW-1:0]    bkt_raddr;

	logic             out_free;
	logic             clearing;
	logic             rd_en;
	logic             upd_go;

	logic             bkt_we;
	logic [AW-1:0]    bkt_waddr;
	logic [63:0]      bkt_wdata;
	logic [63:0]      bkt_rdata;
	logic             tot_we;
	logic [CW-1:0]    tot_waddr;
	logic [CW-1:0]    tot_raddr;
	totals_t          tot_wdata;
	logic [TOT_W-1:0] tot_rdata_raw;
	totals_t          tot_rdata;

	logic [63:0]      cnt_new;
	totals_t          tot_new;

	// bucket selection from the held item
	llh_map #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_map (
		.func       (item_q.func),
		.latency_us (item_q.latency_us),
		.read_bucket(item_q.read_bucket),
		.bucket     (map_bucket),
		.lower_bound(map_lbound)
	);

	assign cls_ok    = ({30'd0, item_q.op_class} < 32'(NUM_CLASSES));
	assign bkt_raddr = AW'(item_q.op_class) * AW'(NUM_BUCKETS) + AW'(map_bucket);
	assign tot_raddr = CW'(item_q.op_class);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (sample_valid) begin
					state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// control outputs
	always_comb begin
		sample_stall = 1'b1;
		clearing     = 1'b0;
		rd_en        = 1'b0;
		upd_go       = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clearing = 1'b1;
			end
			ST_IDLE: begin
				sample_stall = 1'b0;
			end
			ST_MAP: begin
				rd_en = 1'b1;
			end
			ST_UPD: begin
				upd_go = out_free;
			end
			default: begin
				sample_stall = 1'b1;
			end
		endcase
	end

	assign out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// item capture and address stage
	always_ff @(posedge clk) begin
		if (!sample_stall && sample_valid) begin
			item_q <= sample;
		end
		if (rd_en) begin
			bucket_q <= map_bucket;
			lbound_q <= map_lbound;
			addr_q   <= bkt_raddr;
			cls_ok_q <= cls_ok;
			rec_ok_q <= cls_ok && (item_q.func == FUNC_RECORD);
		end
	end

	// update arithmetic on the read data
	assign tot_rdata = totals_t'(tot_rdata_raw);
	always_comb begin
		cnt_new = bkt_rdata;
		tot_new = tot_rdata;
		if (item_q.func == FUNC_RECORD) begin
			cnt_new         = bkt_rdata + 64'd1;
			tot_new.op_cnt  = tot_rdata.op_cnt + 64'd1;
			tot_new.lat_sum = tot_rdata.lat_sum + item_q.latency_us;
			if (item_q.encrypted_op) begin
				tot_new.enc_sum = tot_rdata.enc_sum + item_q.latency_us;
			end
		end
	end

	// memory write ports: clearing pass or write-back
	assign bkt_we    = clearing || (upd_go && rec_ok_q);
	assign bkt_waddr = clearing ? clr_q : addr_q;
	assign bkt_wdata = clearing ? 64'd0 : cnt_new;
	assign tot_we    = (clearing && (clr_q < AW'(NUM_CLASSES))) || (upd_go && rec_ok_q);
	assign tot_waddr = clearing ? CW'(clr_q) : CW'(item_q.op_class);
	assign tot_wdata = clearing ? '0 : tot_new;

	llh_ram #(
		.WIDTH(64),
		.DEPTH(DEPTH)
	) u_bkt_ram (
		.clk    (clk),
		.wr_en  (bkt_we),
		.wr_addr(bkt_waddr),
		.wr_data(bkt_wdata),
		.rd_en  (rd_en),
		.rd_addr(bkt_raddr),
		.rd_data(bkt_rdata)
	);

	llh_ram #(
		.WIDTH(TOT_W),
		.DEPTH(NUM_CLASSES)
	) u_tot_ram (
		.clk    (clk),
		.wr_en  (tot_we),
		.wr_addr(tot_waddr),
		.wr_data(TOT_W'(tot_wdata)),
		.rd_en  (rd_en),
		.rd_addr(tot_raddr),
		.rd_data(tot_rdata_raw)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			out_q.bucket_index       <= 6'(bucket_q);
			out_q.bucket_lower_bound <= lbound_q;
			out_q.bucket_count        <= cls_ok_q ? cnt_new : 64'd0;
			out_q.class_latency_sum   <= cls_ok_q ? tot_new.lat_sum : 64'd0;
			out_q.class_op_count      <= cls_ok_q ? tot_new.op_cnt : 64'd0;
			out_q.class_encrypted_sum <= cls_ok_q ? tot_new.enc_sum : 64'd0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef ASSERT_OFF
	// a new result only appears from the write-back step
	a_result_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_UPD))
		else $error("result appeared without a write-back step");

	// a counter write-back always adds exactly one to the value read
	a_count_plus_one: assert property (@(posedge clk) disable iff (!arst_n)
		(bkt_we && !clearing) |-> (bkt_wdata == bkt_rdata + 64'd1))
		else $error("bucket counter write-back is not read value plus one");

	// a held result blocks the write-back of the next item
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && result_valid && result_stall) |=> (state_q == ST_UPD))
		else $error("write-back completed while the output was stalled");

	// no sample is taken until the clearing pass is done
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> sample_stall)
		else $error("sample accepted during clearing pass");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for log_linear_latency_histogram
// Drives record and read items through the valid/stall channels, keeps its
// own copy of the histogram and class totals, and checks every result item
// field by field. A directed table comes first, then random traffic with
// idle bursts on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import llh_pkg::*;

	localparam int NCLASS       = 4;
	localparam int NBUCKET      = 51;
	localparam int RANDOM_ITEMS = 1800;
	localparam int PRESSURE_AT  = 500;
	localparam int QUIET_FROM   = 1500;
	localparam int HOLD_CYCLES  = 120;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 8;

	// Operation classes
	localparam logic [1:0] CLS_CMD   = 2'd0;
	localparam logic [1:0] CLS_READ  = 2'd1;
	localparam logic [1:0] CLS_WRITE = 2'd2;
	localparam logic [1:0] CLS_TXN   = 2'd3;

	localparam logic [40:0] LB_TOP = 41'h10000000000;

	typedef struct {
		sample_t s;
		bit      typed;
		result_t r;
	} vec_t;

	logic    clk;
	logic    arst_n;
	logic    sample_valid;
	logic    sample_stall;
	sample_t sample;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	// Shadow copy of the block's stores
	logic [63:0] bucket_cnt [NCLASS][NBUCKET];
	logic [63:0] lat_sum [NCLASS];
	logic [63:0] op_cnt [NCLASS];
	logic [63:0] enc_sum [NCLASS];

	result_t due_results [$];
	vec_t    plan [$];
	int      mismatches;
	int      quiet_cycles;
	bit      idle_on;
	bit      hold_request;

	log_linear_latency_histogram #(
		.NUM_CLASSES(NCLASS),
		.NUM_BUCKETS(NBUCKET)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Bucket a latency falls into
	function automatic int bucket_of(logic [63:0] v);
		int l;
		int b;
		if (v == 64'd0) begin
			return 0;
		end
		l = 63;
		while (!v[l]) begin
			l--;
		end
		if (l < SPLIT_LOW) begin
			b = l;
		end else if (l < SPLIT_HIGH) begin
			b = 2 * l - SPLIT_LOW;
			if (v >= (64'd3 << (l - 1))) begin
				b++;
			end
		end else begin
			b = l + TAIL_OFFSET;
		end
		if (b > NBUCKET - 1) begin
			b = NBUCKET - 1;
		end
		return b;
	endfunction

	// Smallest latency that lands in bucket b
	function automatic logic [40:0] bucket_floor(int b);
		int          k;
		int          oct;
		logic [63:0] v;
		if (b == 0) begin
			v = 64'd0;
		end else if (b < SPLIT_LOW) begin
			v = 64'd1 << b;
		end else if (b < SPLIT_LOW + 2 * (SPLIT_HIGH - SPLIT_LOW)) begin
			k   = b - SPLIT_LOW;
			oct = SPLIT_LOW + k / 2;
			v   = 64'd1 << oct;
			if (k % 2 == 1) begin
				v |= 64'd1 << (oct - 1);
			end
		end else begin
			k = b - TAIL_OFFSET;
			if (k > 63) begin
				k = 63;
			end
			v = 64'd1 << k;
		end
		return v[40:0];
	endfunction

	// Apply one item to the shadow stores and return the result it should give
	function automatic result_t histo_apply(sample_t s);
		result_t r;
		int      b;
		int      cls;
		cls = s.op_class;
		if (s.func == FUNC_RECORD) begin
			b = bucket_of(s.latency_us);
			if (cls < NCLASS) begin
				bucket_cnt[cls][b] += 64'd1;
				op_cnt[cls]        += 64'd1;
				lat_sum[cls]       += s.latency_us;
				if (s.encrypted_op) begin
					enc_sum[cls] += s.latency_us;
				end
			end
		end else begin
			b = s.read_bucket;
			if (b > NBUCKET - 1) begin
				b = NBUCKET - 1;
			end
		end
		r.bucket_index       = 6'(b);
		r.bucket_lower_bound = bucket_floor(b);
		if (cls < NCLASS) begin
			r.bucket_count        = bucket_cnt[cls][b];
			r.class_latency_sum   = lat_sum[cls];
			r.class_op_count      = op_cnt[cls];
			r.class_encrypted_sum = enc_sum[cls];
		end else begin
			r.bucket_count        = '0;
			r.class_latency_sum   = '0;
			r.class_op_count      = '0;
			r.class_encrypted_sum = '0;
		end
		return r;
	endfunction

	function automatic sample_t mk_sample(logic f, logic [63:0] lat, logic [1:0] cls,
			logic enc, logic [5:0] rb);
		sample_t s;
		s.func         = f;
		s.latency_us   = lat;
		s.op_class     = cls;
		s.encrypted_op = enc;
		s.read_bucket  = rb;
		return s;
	endfunction

	function automatic result_t mk_result(logic [5:0] idx, logic [63:0] cnt, logic [40:0] lb,
			logic [63:0] sum, logic [63:0] ops, logic [63:0] enc);
		result_t r;
		r.bucket_index        = idx;
		r.bucket_count        = cnt;
		r.bucket_lower_bound  = lb;
		r.class_latency_sum   = sum;
		r.class_op_count      = ops;
		r.class_encrypted_sum = enc;
		return r;
	endfunction

	task automatic add_row(sample_t s, bit typed, result_t r);
		vec_t v;
		v.s     = s;
		v.typed = typed;
		v.r     = r;
		plan.push_back(v);
	endtask

	// Log-spread latency with boundary values mixed in
	function automatic logic [63:0] rand_latency();
		int l;
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return $urandom_range(0, 1) ? '1 : 64'd1;
			2: begin
				l = $urandom_range(1, 62);
				return (64'd3 << (l - 1)) + 64'($urandom_range(0, 2)) - 64'd1;
			end
			3: return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Offer one item, hold it until taken, and queue its expected result.
	// Called and returning at a falling edge.
	task automatic send_item(sample_t s, bit typed, result_t typed_r);
		result_t r;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do begin
			@(posedge clk);
		end while (sample_stall);
		r = histo_apply(s);
		due_results.push_back(typed ? typed_r : r);
		@(negedge clk);
	endtask

	// Sender
	initial begin
		sample_t s;
		logic    f;
		logic [5:0] rb;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		idle_on      = 1'b1;
		hold_request = 1'b0;
		mismatches   = 0;
		for (int c = 0; c < NCLASS; c++) begin
			lat_sum[c] = '0;
			op_cnt[c]  = '0;
			enc_sum[c] = '0;
			for (int b = 0; b < NBUCKET; b++) begin
				bucket_cnt[c][b] = '0;
			end
		end

		// Directed table: cleared state, extremes, wrap, bucket boundaries
		add_row(mk_sample(FUNC_READ, 64'd0, CLS_CMD, 1'b0, 6'd0), 1'b1,
			mk_result(6'd0, 64'd0, 41'd0, 64'd0, 64'd0, 64'd0));
		add_row(mk_sample(FUNC_READ, '1, CLS_TXN, 1'b1, 6'd63), 1'b1,
			mk_result(6'd50, 64'd0, LB_TOP, 64'd0, 64'd0, 64'd0));
		add_row(mk_sample(FUNC_RECORD, 64'd0, CLS_CMD, 1'b0, 6'd0), 1'b1,
			mk_result(6'd0, 64'd1, 41'd0, 64'd0, 64'd1, 64'd0));
		add_row(mk_sample(FUNC_RECORD, '1, CLS_READ, 1'b1, 6'd63), 1'b1,
			mk_result(6'd50, 64'd1, LB_TOP, '1, 64'd1, '1));
		// sums wrap back to zero
		add_row(mk_sample(FUNC_RECORD, 64'd1, CLS_READ, 1'b1, 6'd0), 1'b1,
			mk_result(6'd0, 64'd1, 41'd0, 64'd0, 64'd2, 64'd0));
		add_row(mk_sample(FUNC_RECORD, 64'd2, CLS_WRITE, 1'b0, 6'd0), 1'b1,
			mk_result(6'd1, 64'd1, 41'd2, 64'd2, 64'd1, 64'd0));
		add_row(mk_sample(FUNC_RECORD, 64'd2047, CLS_WRITE, 1'b1, 6'd0), 1'b0, '0);
		add_row(mk_sample(FUNC_RECORD, 64'd2048, CLS_WRITE, 1'b0, 6'd0), 1'b0, '0);
		add_row(mk_sample(FUNC_RECORD, 64'd3071, CLS_WRITE, 1'b1, 6'd0), 1'b0, '0);
		add_row(mk_sample(FUNC_RECORD, 64'd3072, CLS_TXN, 1'b1, 6'd0), 1'b0, '0);
		add_row(mk_sample(FUNC_RECORD, (64'd1 << 21) - 64'd1, CLS_TXN, 1'b0, 6'd0), 1'b0, '0);
		add_row(mk_sample(FUNC_RECORD, 64'd1 << 21, CLS_TXN, 1'b1, 6'd0), 1'b0, '0);
		add_row(mk_sample(FUNC_RECORD, (64'd1 << 40) - 64'd1, CLS_CMD, 1'b1, 6'd0), 1'b0, '0);
		add_row(mk_sample(FUNC_RECORD, 64'd1 << 40, CLS_CMD, 1'b0, 6'd0), 1'b0, '0);
		add_row(mk_sample(FUNC_RECORD, 64'h8000_0000_0000_0000, CLS_CMD, 1'b1, 6'd0),
			1'b0, '0);
		add_row(mk_sample(FUNC_RECORD, 64'h5555_5555_5555_5555, CLS_READ, 1'b1, 6'h2a),
			1'b0, '0);
		add_row(mk_sample(FUNC_RECORD, 64'hAAAA_AAAA_AAAA_AAAA, CLS_TXN, 1'b0, 6'h15),
			1'b0, '0);
		add_row(mk_sample(FUNC_READ, 64'd0, CLS_READ, 1'b0, 6'd50), 1'b0, '0);
		add_row(mk_sample(FUNC_READ, 64'd0, CLS_CMD, 1'b0, 6'd11), 1'b0, '0);
		add_row(mk_sample(FUNC_READ, '1, CLS_TXN, 1'b1, 6'd12), 1'b0, '0);
		add_row(mk_sample(FUNC_READ, 64'd0, CLS_TXN, 1'b0, 6'd30), 1'b0, '0);
		add_row(mk_sample(FUNC_READ, 64'd0, CLS_TXN, 1'b0, 6'd31), 1'b0, '0);
		add_row(mk_sample(FUNC_READ, 64'd5, CLS_WRITE, 1'b1, 6'd51), 1'b0, '0);
		add_row(mk_sample(FUNC_READ, 64'd0, CLS_CMD, 1'b0, 6'd49), 1'b0, '0);

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			send_item(plan[i].s, plan[i].typed, plan[i].r);
		end

		// Random traffic: mostly records, reads spread over every bucket
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == PRESSURE_AT) begin
				hold_request = 1'b1;
			end
			if (n == QUIET_FROM) begin
				idle_on = 1'b0;
			end
			f  = ($urandom_range(0, 2) == 0) ? FUNC_READ : FUNC_RECORD;
			rb = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(51, 63))
				: 6'($urandom_range(0, 50));
			s  = mk_sample(f, rand_latency(), 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), rb);
			send_item(s, 1'b0, '0);
		end
		sample_valid <= 1'b0;

		// Drain, then a short tail for stray results
		while (due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off on request
	initial begin
		int   run_len;
		logic st;
		result_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				st      = 1'b1;
				run_len = HOLD_CYCLES;
			end else if (idle_on) begin
				st      = 1'($urandom_range(0, 1));
				run_len = $urandom_range(1, 16);
			end else begin
				st      = 1'b0;
				run_len = 1;
			end
			result_stall <= st;
			repeat (run_len) @(negedge clk);
		end
	end

	// Result checker and watchdog
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (due_results.size() == 0) begin
				report_mismatch("unexpected result item", result.bucket_count, 64'd0);
			end else begin
				want = due_results.pop_front();
				if (result.bucket_index !== want.bucket_index)
					report_mismatch("bucket_index", 64'(result.bucket_index),
						64'(want.bucket_index));
				if (result.bucket_count !== want.bucket_count)
					report_mismatch("bucket_count", result.bucket_count, want.bucket_count);
				if (result.bucket_lower_bound !== want.bucket_lower_bound)
					report_mismatch("bucket_lower_bound", 64'(result.bucket_lower_bound),
						64'(want.bucket_lower_bound));
				if (result.class_latency_sum !== want.class_latency_sum)
					report_mismatch("class_latency_sum", result.class_latency_sum,
						want.class_latency_sum);
				if (result.class_op_count !== want.class_op_count)
					report_mismatch("class_op_count", result.class_op_count,
						want.class_op_count);
				if (result.class_encrypted_sum !== want.class_encrypted_sum)
					report_mismatch("class_encrypted_sum", result.class_encrypted_sum,
						want.class_encrypted_sum);
			end
		end
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", quiet_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule
